### hw/rtl/icdf_pkg.sv
// icdf_pkg: shared constants, codes and command/status types for the
// inverse cdf table sampler. no dependencies; used by every rtl file.
package icdf_pkg;

  // table geometry
  localparam int TABLE_POINTS = 1024;
  localparam int TBL_DEPTH    = TABLE_POINTS + 1;
  localparam int IDX_W        = $clog2(TBL_DEPTH);

  // datapath widths
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = DATA_W + IDX_W + 2;
  localparam int DIV_STEPS = DATA_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // configuration port
  localparam int REG_ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_BASE_VAL  = 2'd0,
    REG_STEP_SIZE = 2'd1,
    REG_CDF_RANGE = 2'd2
  } reg_idx_t;

  // request function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MULU,
    S_LDU,
    S_SCAN,
    S_DIV,
    S_MULF,
    S_ACCF,
    S_ADDP,
    S_DONE
  } state_t;

  // multiplier operand select
  typedef enum logic [1:0] {
    MUL_U,
    MUL_N,
    MUL_FRAC,
    MUL_K
  } mul_sel_t;

  // accumulator operation
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_MIN,
    ACC_MIN_FRAC,
    ACC_ADD_PROD
  } acc_op_t;

  typedef struct packed {
    logic     tbl_we;
    logic     cap_in;
    logic     ld_u;
    logic     scan_start;
    logic     scan_en;
    logic     div_en;
    logic     out_load;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic hit_zero;
    logic miss;
  } stat_t;

endpackage

### hw/rtl/inverse_cdf_table_sampler.sv
// inverse_cdf_table_sampler: top level with the configuration registers,
// joining icdf_ctrl and icdf_dp. depends on icdf_pkg.
//
// A load request (func 0) writes one cdf table entry; indexes above the table
// size are dropped. A sample request (func 1) scales uniform by cdf_range,
// scans the table linearly from entry 0 for the first entry not below that
// value, divides out the fraction between grid points and returns the base
// value plus step_size times the fractional index, saturated.
// A sample scans the table one entry per cycle through the table's single
// read port, and the interpolation fraction comes from a restoring divider.
// A sample that stops at entry 0 or passes the last entry skips the divider.
// The input stalls while a sample is in work; a finished result waits in the
// output register and the next request is taken meanwhile.
module inverse_cdf_table_sampler
  import icdf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_func,
  input  logic [IDX_W-1:0]      in_entry_index,
  input  logic [DATA_W-1:0]     in_entry_value,
  input  logic [DATA_W-1:0]     in_uniform,
  input  logic                  in_last_in,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_W-1:0]     out_sample,
  output logic                  out_clamped,
  output logic                  out_last_out,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  logic [DATA_W-1:0] base_val_r, step_size_r, cdf_range_r;
  logic              cfg_wr;
  reg_idx_t          reg_idx;
  cmd_t              cmd;
  stat_t             stat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[REG_ADDR_W-1:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_val_r  <= '0;
      step_size_r <= DATA_W'(64);
      cdf_range_r <= '1;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_BASE_VAL:  base_val_r  <= pwdata;
        REG_STEP_SIZE: step_size_r <= pwdata;
        REG_CDF_RANGE: cdf_range_r <= pwdata;
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_idx)
      REG_BASE_VAL:  prdata = base_val_r;
      REG_STEP_SIZE: prdata = step_size_r;
      REG_CDF_RANGE: prdata = cdf_range_r;
      default:       prdata = '0;
    endcase
  end

  icdf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  icdf_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .in_uniform     (in_uniform),
    .in_last_in     (in_last_in),
    .base_val       (base_val_r),
    .step_size      (step_size_r),
    .cdf_range      (cdf_range_r),
    .out_sample     (out_sample),
    .out_clamped    (out_clamped),
    .out_last_out   (out_last_out)
  );

endmodule

### hw/rtl/icdf_ctrl.sv
// icdf_ctrl: sequencing state machine for loads and samples, input stall
// and output valid. depends on icdf_pkg.
module icdf_ctrl
  import icdf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  in_func,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               in_accept;
  logic               out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept && (in_func == FUNC_SAMPLE)) state_nxt = S_MULU;
      end
      S_MULU: state_nxt = S_LDU;
      S_LDU:  state_nxt = S_SCAN;
      S_SCAN: begin
        if (stat.hit && stat.hit_zero) state_nxt = S_DONE;
        else if (stat.hit)             state_nxt = S_DIV;
        else if (stat.miss)            state_nxt = S_ADDP;
      end
      S_DIV: begin
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = S_MULF;
      end
      S_MULF: state_nxt = S_ACCF;
      S_ACCF: state_nxt = S_ADDP;
      S_ADDP: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    cmd.mul_sel = MUL_U;
    cmd.acc_op  = ACC_HOLD;
    case (state_r)
      S_IDLE: begin
        cmd.tbl_we = in_accept && (in_func == FUNC_LOAD);
        cmd.cap_in = in_accept && (in_func == FUNC_SAMPLE);
      end
      S_MULU: cmd.mul_sel = MUL_U;
      S_LDU: begin
        cmd.ld_u       = 1'b1;
        cmd.scan_start = 1'b1;
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        cmd.mul_sel = MUL_N;
        if ((stat.hit && stat.hit_zero) || stat.miss) cmd.acc_op = ACC_MIN;
      end
      S_DIV:  cmd.div_en = 1'b1;
      S_MULF: cmd.mul_sel = MUL_FRAC;
      S_ACCF: begin
        cmd.acc_op  = ACC_MIN_FRAC;
        cmd.mul_sel = MUL_K;
      end
      S_ADDP: cmd.acc_op = ACC_ADD_PROD;
      S_DONE: cmd.out_load = out_free;
      default: cmd.acc_op = ACC_HOLD;
    endcase
  end

  // divide step counter and output valid
  always_comb begin
    cnt_nxt = (state_r == S_DIV) ? cnt_r + 1'b1 : '0;
    if (cmd.out_load)    out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && out_stall))
    else $error("pending result overwritten");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not presented");

  a_hit_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !(stat.hit && stat.miss))
    else $error("scan reports hit and miss together");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && (cnt_r == CNT_W'(DIV_STEPS - 1)) |=> (state_r == S_MULF))
    else $error("divide did not end after its step count");
`endif

endmodule

### hw/rtl/icdf_dp.sv
// icdf_dp: cdf table memory, linear search, restoring divider, shared
// multiplier, accumulator, saturation and result registers. depends on icdf_pkg.
module icdf_dp
  import icdf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic [IDX_W-1:0]  in_entry_index,
  input  logic [DATA_W-1:0] in_entry_value,
  input  logic [DATA_W-1:0] in_uniform,
  input  logic              in_last_in,
  input  logic [DATA_W-1:0] base_val,
  input  logic [DATA_W-1:0] step_size,
  input  logic [DATA_W-1:0] cdf_range,
  output logic [DATA_W-1:0] out_sample,
  output logic              out_clamped,
  output logic              out_last_out
);

  logic [DATA_W-1:0] tbl_mem [TBL_DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic              tbl_we_ok;
  logic              rd_go;

  logic [DATA_W-1:0] uni_r, u_r, prev_r;
  logic              last_r;
  logic [IDX_W-1:0]  k_r, j_r, kf_r;
  logic              iss_end_r, d_vld_r;
  logic              u_le_data;

  logic [DATA_W-1:0] rem_r, den_r, q_r;
  logic              full_r, clamp_r;
  logic [DATA_W:0]   rem_sh;

  logic [DATA_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]  acc_r, min_sext;
  logic              sat_hi, sat_lo;

  logic [DATA_W-1:0] sample_r;
  logic              clamped_r, last_out_r;

  // table write, range checked
  assign tbl_we_ok = cmd.tbl_we && (in_entry_index <= IDX_W'(TABLE_POINTS));

  always_ff @(posedge clk) begin
    if (tbl_we_ok) tbl_mem[in_entry_index] <= in_entry_value;
  end

  // search status
  assign u_le_data     = (u_r <= rd_data_r);
  assign stat.hit      = d_vld_r && u_le_data;
  assign stat.miss     = d_vld_r && !u_le_data && (j_r == IDX_W'(TABLE_POINTS));
  assign stat.hit_zero = (j_r == '0);
  assign rd_go         = cmd.scan_en && !iss_end_r && !stat.hit && !stat.miss;

  always_ff @(posedge clk) begin
    if (rd_go) rd_data_r <= tbl_mem[k_r];
  end

  // read address sequencing, one entry per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r       <= '0;
      iss_end_r <= 1'b0;
      d_vld_r   <= 1'b0;
    end else if (cmd.scan_start) begin
      k_r       <= '0;
      iss_end_r <= 1'b0;
      d_vld_r   <= 1'b0;
    end else begin
      d_vld_r <= rd_go;
      if (rd_go) begin
        if (k_r == IDX_W'(TABLE_POINTS)) iss_end_r <= 1'b1;
        else                             k_r       <= k_r + 1'b1;
      end
    end
  end

  // input capture, scaled uniform and search bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      uni_r  <= in_uniform;
      last_r <= in_last_in;
    end
    if (cmd.ld_u) u_r <= prod_r[PROD_W-1:DATA_W];
    if (rd_go) j_r <= k_r;
    if (d_vld_r && !u_le_data) prev_r <= rd_data_r;
    if (cmd.scan_en && stat.hit) begin
      kf_r   <= j_r;
      full_r <= (u_r == rd_data_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)                      clamp_r <= 1'b0;
    else if (cmd.scan_start)         clamp_r <= 1'b0;
    else if (cmd.scan_en && stat.miss) clamp_r <= 1'b1;
  end

  // restoring divider, one quotient bit per cycle
  assign rem_sh = {rem_r, 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.scan_en && stat.hit) begin
      rem_r <= u_r - prev_r;
      den_r <= rd_data_r - prev_r;
      q_r   <= '0;
    end else if (cmd.div_en) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_r <= DATA_W'(rem_sh - {1'b0, den_r});
        q_r   <= {q_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[DATA_W-1:0];
        q_r   <= {q_r[DATA_W-2:0], 1'b0};
      end
    end
  end

  // shared multiplier
  always_comb begin
    case (cmd.mul_sel)
      MUL_U: begin
        mul_a = uni_r;
        mul_b = cdf_range;
      end
      MUL_N: begin
        mul_a = step_size;
        mul_b = DATA_W'(TABLE_POINTS);
      end
      MUL_FRAC: begin
        mul_a = step_size;
        mul_b = q_r;
      end
      MUL_K: begin
        mul_a = step_size;
        mul_b = DATA_W'(kf_r - 1'b1);
      end
      default: begin
        mul_a = uni_r;
        mul_b = cdf_range;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // accumulator
  assign min_sext = {{(ACC_W - DATA_W){base_val[DATA_W-1]}}, base_val};

  always_ff @(posedge clk) begin
    case (cmd.acc_op)
      ACC_MIN:      acc_r <= min_sext;
      ACC_MIN_FRAC: acc_r <= min_sext + {{(ACC_W - DATA_W){1'b0}},
                                         (full_r ? step_size : prod_r[PROD_W-1:DATA_W])};
      ACC_ADD_PROD: acc_r <= acc_r + {1'b0, prod_r[ACC_W-2:0]};
      default:      acc_r <= acc_r;
    endcase
  end

  // saturation to signed 32 bits
  assign sat_hi = !acc_r[ACC_W-1] && (|acc_r[ACC_W-2:DATA_W-1]);
  assign sat_lo = acc_r[ACC_W-1] && !(&acc_r[ACC_W-2:DATA_W-1]);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (sat_hi)      sample_r <= {1'b0, {(DATA_W - 1){1'b1}}};
      else if (sat_lo) sample_r <= {1'b1, {(DATA_W - 1){1'b0}}};
      else             sample_r <= acc_r[DATA_W-1:0];
      clamped_r  <= clamp_r || sat_hi || sat_lo;
      last_out_r <= last_r;
    end
  end

  assign out_sample   = sample_r;
  assign out_clamped  = clamped_r;
  assign out_last_out = last_out_r;

endmodule

### tb/tb_top.sv
// tb_top: self-checking bench for inverse_cdf_table_sampler, table loads and
// interpolated sample draws checked against an in-bench predictor.
// depends on icdf_pkg and the inverse_cdf_table_sampler rtl.
`timescale 1ns / 100ps

module tb_top;
  import icdf_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int LOAD_SETTLE = 50;
  localparam int END_SETTLE  = 100;
  localparam longint SAT_HI  = 2147483647;
  localparam longint SAT_LO  = -SAT_HI - 1;

  typedef enum {
    SHAPE_STEEP,
    SHAPE_LINEAR,
    SHAPE_LOW,
    SHAPE_JAGGED
  } table_shape_t;

  typedef struct packed {
    logic [DATA_W-1:0] sample;
    logic              clamped;
    logic              last_out;
  } sample_result_t;

  // predictor with its own copy of the table and registers
  class sample_scoreboard;
    logic [DATA_W-1:0] cdf_copy [TBL_DEPTH];
    logic [DATA_W-1:0] base_val;
    logic [DATA_W-1:0] step_size;
    logic [DATA_W-1:0] cdf_range;
    sample_result_t    expected_samples[$];
    int                failures;

    function new();
      base_val  = '0;
      step_size = 32'd64;
      cdf_range = '1;
      failures  = 0;
      foreach (cdf_copy[i]) cdf_copy[i] = '0;
    endfunction

    function void set_reg(reg_idx_t r, logic [DATA_W-1:0] v);
      case (r)
        REG_BASE_VAL:  base_val  = v;
        REG_STEP_SIZE: step_size = v;
        REG_CDF_RANGE: cdf_range = v;
        default: ;
      endcase
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("ERROR at %0t: %s", $time, msg);
    endfunction

    // accepted request: table write or predicted draw
    function void take_request(logic func, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value,
                               logic [DATA_W-1:0] uniform, logic last);
      logic [PROD_W-1:0] scaled, step_wide, frac, term1, term2;
      logic [DATA_W-1:0] u, num, den;
      longint            total;
      int                k;
      sample_result_t    r;
      if (func == FUNC_LOAD) begin
        if (idx <= TABLE_POINTS) cdf_copy[idx] = value;
        return;
      end
      scaled    = PROD_W'(uniform) * PROD_W'(cdf_range);
      u         = scaled[PROD_W-1:DATA_W];
      step_wide = PROD_W'(step_size);
      k = 0;
      while (k <= TABLE_POINTS && u > cdf_copy[k]) k++;
      r.clamped  = 1'b0;
      r.last_out = last;
      if (k == 0) begin
        // at or below the first entry
        total = longint'($signed(base_val));
      end else if (k > TABLE_POINTS) begin
        // beyond the last entry: pinned to the top of the grid
        r.clamped = 1'b1;
        total = longint'($signed(base_val)) + longint'(step_wide * PROD_W'(TABLE_POINTS));
      end else begin
        // linear interpolation between grid points k-1 and k
        num   = u - cdf_copy[k-1];
        den   = cdf_copy[k] - cdf_copy[k-1];
        frac  = {num, 32'h0} / PROD_W'(den);
        term1 = step_wide * PROD_W'(k - 1);
        term2 = (frac >= 64'h1_0000_0000) ? step_wide : (step_wide * frac) >> DATA_W;
        total = longint'($signed(base_val)) + longint'(term1 + term2);
      end
      // saturate to signed 32 bits
      if (total > SAT_HI) begin
        r.sample  = 32'h7FFF_FFFF;
        r.clamped = 1'b1;
      end else if (total < SAT_LO) begin
        r.sample  = 32'h8000_0000;
        r.clamped = 1'b1;
      end else begin
        r.sample = total[DATA_W-1:0];
      end
      expected_samples.push_back(r);
    endfunction

    // accepted result against the oldest prediction
    function void check_sample(logic [DATA_W-1:0] sample, logic clamped, logic last);
      sample_result_t want;
      if (expected_samples.size() == 0) begin
        note_failure($sformatf("unexpected result: sample %h clamped %b last %b",
                               sample, clamped, last));
        return;
      end
      want = expected_samples.pop_front();
      if (want.sample !== sample || want.clamped !== clamped || want.last_out !== last)
        note_failure($sformatf("sample exp %h clamped %b last %b, got %h clamped %b last %b",
                               want.sample, want.clamped, want.last_out,
                               sample, clamped, last));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_func = FUNC_LOAD;
  logic [IDX_W-1:0]      in_entry_index = '0;
  logic [DATA_W-1:0]     in_entry_value = '0;
  logic [DATA_W-1:0]     in_uniform = '0;
  logic                  in_last_in = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [DATA_W-1:0]     out_sample;
  logic                  out_clamped;
  logic                  out_last_out;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [REG_ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0]     pwdata = '0;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;

  sample_scoreboard board;
  int burst_left = 0;
  int stall_hold = 0;
  int cycle_count = 0;
  // top entry of the last loaded table; it holds all ones, so no search goes past it
  int table_top = 0;

  inverse_cdf_table_sampler uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .in_uniform     (in_uniform),
    .in_last_in     (in_last_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample     (out_sample),
    .out_clamped    (out_clamped),
    .out_last_out   (out_last_out),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("inverse_cdf_table_sampler: mismatch");
      $finish;
    end
  end

  // result side stall pattern: free runs, short stalls and long holds
  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      case ($urandom_range(0, 5))
        0, 1: begin
          out_stall  <= 1'b0;
          stall_hold <= $urandom_range(0, 40);
        end
        2, 3: begin
          out_stall  <= 1'b1;
          stall_hold <= $urandom_range(0, 6);
        end
        4: begin
          out_stall  <= 1'($urandom_range(0, 1));
          stall_hold <= 0;
        end
        default: begin
          out_stall  <= 1'b1;
          stall_hold <= $urandom_range(20, 60);
        end
      endcase
    end
  end

  // result monitor: values at the falling edge are those seen by the next rising edge
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_sample(out_sample, out_clamped, out_last_out);
  end

  // one request, sent in bursts with random gaps between them
  task automatic send_request(logic func, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value,
                              logic [DATA_W-1:0] uniform, logic last);
    int  gap;
    logic taken;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_func        <= func;
    in_entry_index <= idx;
    in_entry_value <= value;
    in_uniform     <= uniform;
    in_last_in     <= last;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    board.take_request(func, idx, value, uniform, last);
  endtask

  task automatic send_sample(logic [DATA_W-1:0] uniform, logic last);
    send_request(FUNC_SAMPLE, IDX_W'($urandom_range(0, 2047)), $urandom, uniform, last);
  endtask

  task automatic send_load(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
    send_request(FUNC_LOAD, idx, value, $urandom, 1'($urandom_range(0, 1)));
  endtask

  // hold the sender until every predicted draw has come back
  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.expected_samples.size() != 0);
  endtask

  task automatic write_reg(reg_idx_t r, logic [DATA_W-1:0] v);
    logic done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_ADDR_W'(r) << 2;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      done = pready;
      @(posedge clk);
    end while (!done);
    board.set_reg(r, v);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // registers change only with the block idle
  task automatic reconfigure(logic [DATA_W-1:0] min_v, logic [DATA_W-1:0] step_v,
                             logic [DATA_W-1:0] range_v);
    wait_results();
    repeat (LOAD_SETTLE) @(posedge clk);
    write_reg(REG_BASE_VAL, min_v);
    write_reg(REG_STEP_SIZE, step_v);
    write_reg(REG_CDF_RANGE, range_v);
  endtask

  // rewrite entries 0..points with one cdf shape, all ones at the top
  task automatic load_table(table_shape_t shape, int points);
    logic [DATA_W-1:0] v, prev;
    int i;
    prev = '0;
    for (i = 0; i <= points; i++) begin
      case (shape)
        SHAPE_STEEP:  v = 32'(i + 1) << 27;
        SHAPE_LINEAR: v = 32'(i) * (32'hFFFF_FFFF / 32'(points));
        SHAPE_LOW:    v = 32'(i) * 32'h0007_FFFF;
        default: begin
          // non-monotonic with plateaus
          if ($urandom_range(0, 3) == 0) v = prev;
          else v = $urandom;
        end
      endcase
      // the top entry ends every search
      if (i == points) v = 32'hFFFF_FFFF;
      prev = v;
      send_load(IDX_W'(i), v);
    end
    table_top = points;
  endtask

  // mostly draws, some table rewrites and dropped indexes
  task automatic random_traffic(int count);
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] uni;
    repeat (count) begin
      if ($urandom_range(0, 99) < 70) begin
        case ($urandom_range(0, 4))
          0: uni = $urandom_range(0, 255);
          1: uni = board.cdf_copy[$urandom_range(0, 31)] + $urandom_range(0, 2);
          2: uni = 32'hFFFF_FFFF - $urandom_range(0, 255);
          default: uni = $urandom;
        endcase
        send_sample(uni, 1'($urandom_range(0, 1)));
      end else begin
        // the top entry is never lowered; entries above it are never searched
        case ($urandom_range(0, 3))
          0: idx = IDX_W'($urandom_range(TBL_DEPTH, 2047));
          1: idx = IDX_W'($urandom_range(table_top + 1, TABLE_POINTS));
          default: idx = IDX_W'($urandom_range(0, table_top - 1));
        endcase
        send_load(idx, ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom);
      end
    end
  endtask

  initial begin
    board = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers, steep table
    load_table(SHAPE_STEEP, 31);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b1);
    send_sample(32'h0800_0001, 1'b0);
    send_sample(32'h0800_0002, 1'b1);
    send_sample(32'h3000_0001, 1'b0);
    send_load(IDX_W'(TABLE_POINTS), 32'hFFFF_FFFF);
    send_load(11'h7FF, 32'h0000_0000);
    send_load(IDX_W'(TBL_DEPTH), 32'h0000_0000);
    send_sample(32'h8000_0000, 1'b1);
    random_traffic(50);
    wait_results();
    random_traffic(30);

    // top of the signed range with the widest step: saturation
    reconfigure(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0000, 1'b1);
    random_traffic(30);

    // bottom of the range, zero step and zero cdf span
    reconfigure(32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
    send_sample(32'hFFFF_FFFF, 1'b1);
    random_traffic(15);

    // random settings over a non-monotonic table
    reconfigure($urandom, $urandom_range(0, 32'h00FF_FFFF), $urandom);
    load_table(SHAPE_JAGGED, 24);
    random_traffic(40);

    // linear table, deeper searches
    reconfigure(32'h0000_0000, 32'h0001_0000, 32'hFFFF_FFFF);
    load_table(SHAPE_LINEAR, 64);
    random_traffic(35);

    // low ramp ending in one steep rise: long interpolations at the top
    reconfigure($urandom, 32'h0000_4000, 32'hFFFF_FFFF);
    load_table(SHAPE_LOW, 48);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h4000_0000, 1'b1);
    random_traffic(35);

    wait_results();
    repeat (END_SETTLE) @(posedge clk);
    if (board.failures == 0 && board.expected_samples.size() == 0)
      $display("inverse_cdf_table_sampler: match");
    else
      $display("inverse_cdf_table_sampler: mismatch");
    $finish;
  end

endmodule

### sim.f
hw/rtl/icdf_pkg.sv
hw/rtl/icdf_ctrl.sv
hw/rtl/icdf_dp.sv
hw/rtl/inverse_cdf_table_sampler.sv
tb/tb_top.sv
